FILE: rtl/fpws_pkg.sv
package fpws_pkg;

    localparam logic [31:0] WINDOW_MS   = 32'd1000;
    localparam logic [31:0] MIN_RESTART = 32'd1000;

    localparam int PERIOD_W = 26;
    localparam int COUNT_W  = 20;
    localparam int PROD_W   = PERIOD_W + COUNT_W;
    localparam int DIVD_W   = 40;
    localparam int CNT_W    = 6;
    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd40;

    // Microprogram layout
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PROG_LAST = 4'd11;

    typedef logic [3:0] op_t;
    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_LOAD    = 4'd1;
    localparam op_t OP_INTV    = 4'd2;
    localparam op_t OP_DEC     = 4'd3;
    localparam op_t OP_TGT     = 4'd4;
    localparam op_t OP_DIFF    = 4'd5;
    localparam op_t OP_WAIT    = 4'd6;
    localparam op_t OP_DELTA   = 4'd7;
    localparam op_t OP_DIVINIT = 4'd8;
    localparam op_t OP_DIVSTEP = 4'd9;
    localparam op_t OP_PUB     = 4'd10;
    localparam op_t OP_OUT     = 4'd11;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NONE     = 3'd0;
    localparam cond_t C_NO_IN    = 3'd1;
    localparam cond_t C_UNCAPPED = 3'd2;
    localparam cond_t C_SHORT    = 3'd3;
    localparam cond_t C_DIV_MORE = 3'd4;
    localparam cond_t C_OUT_BUSY = 3'd5;

    localparam pc_t PC_LOAD    = 4'd0;
    localparam pc_t PC_DELTA   = 4'd6;
    localparam pc_t PC_DIVSTEP = 4'd9;
    localparam pc_t PC_OUT     = 4'd11;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic uncapped;
        logic short_win;
        logic div_more;
        logic out_busy;
    } status_t;

    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        case (pc)
            4'd0:    w = '{OP_LOAD,    C_NO_IN,    PC_LOAD};
            4'd1:    w = '{OP_INTV,    C_UNCAPPED, PC_DELTA};
            4'd2:    w = '{OP_DEC,     C_NONE,     PC_LOAD};
            4'd3:    w = '{OP_TGT,     C_NONE,     PC_LOAD};
            4'd4:    w = '{OP_DIFF,    C_NONE,     PC_LOAD};
            4'd5:    w = '{OP_WAIT,    C_NONE,     PC_LOAD};
            4'd6:    w = '{OP_DELTA,   C_NONE,     PC_LOAD};
            4'd7:    w = '{OP_NOP,     C_SHORT,    PC_OUT};
            4'd8:    w = '{OP_DIVINIT, C_NONE,     PC_LOAD};
            4'd9:    w = '{OP_DIVSTEP, C_DIV_MORE, PC_DIVSTEP};
            4'd10:   w = '{OP_PUB,     C_NONE,     PC_LOAD};
            4'd11:   w = '{OP_OUT,     C_OUT_BUSY, PC_OUT};
            default: w = '{OP_NOP,     C_NONE,     PC_LOAD};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

FILE: rtl/fpws_seq.sv
module fpws_seq
    import fpws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic jump;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NONE:     jump = 1'b0;
            C_NO_IN:    jump = !status.in_fire;
            C_UNCAPPED: jump = status.uncapped;
            C_SHORT:    jump = status.short_win;
            C_DIV_MORE: jump = status.div_more;
            C_OUT_BUSY: jump = status.out_busy;
            default:    jump = 1'b0;
        endcase
    end

    // Jump if taken, else step, wrapping to fetch after the last word
    always_comb
    begin
        if (jump)
            pc_next = ctrl.target;
        else if (pc_reg == PROG_LAST)
            pc_next = PC_LOAD;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_LOAD;
        else
            pc_reg <= pc_next;
    end

endmodule

FILE: rtl/fpws_div.sv
module fpws_div
    import fpws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                step,
    input  logic [DIVD_W-1:0]   dividend,
    input  logic [COUNT_W-1:0]  divisor,
    output logic [DIVD_W-1:0]   quotient,
    output logic                more
);

    logic [DIVD_W-1:0]  q_reg;
    logic [COUNT_W:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COUNT_W:0]   rem_sh;
    logic               ge;

    // One quotient bit per cycle while step is high, restoring
    assign rem_sh   = {rem_reg[COUNT_W-1:0], q_reg[DIVD_W-1]};
    assign ge       = rem_sh >= {1'b0, divisor};
    assign quotient = q_reg;
    assign more     = cnt_reg != {{(CNT_W-1){1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            q_reg   <= '0;
            rem_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_STEPS;
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            q_reg   <= {q_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
        end
    end

endmodule

FILE: rtl/fpws_dp.sv
module fpws_dp
    import fpws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_t                ctrl,
    output status_t              status,
    input  logic                 cfg_wr_en,
    input  logic [PERIOD_W-1:0]  cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          now_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          wait_ms,
    output logic [31:0]          delta_ms,
    output logic                 window_done,
    output logic [COUNT_W-1:0]   fps,
    output logic [31:0]          avg_ms_q8,
    output logic [31:0]          min_ms,
    output logic [31:0]          max_ms
);

    logic [PERIOD_W-1:0] period_reg;
    logic [31:0]         now_reg;
    logic [COUNT_W-1:0]  fc_reg;
    logic [31:0]         last_reg;
    logic [31:0]         ws_reg;
    logic [31:0]         min_reg;
    logic [31:0]         max_reg;
    logic [31:0]         sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [31:0]         tgt_reg;
    logic [31:0]         d_reg;
    logic [31:0]         wait_reg;
    logic [31:0]         eff_reg;
    logic [31:0]         delta_reg;
    logic [31:0]         span_reg;
    logic                done_reg;
    logic [COUNT_W-1:0]  held_fps_reg;
    logic [31:0]         held_avg_reg;
    logic [31:0]         held_min_reg;
    logic [31:0]         held_max_reg;
    logic                out_valid_reg;

    logic [31:0]         interval;
    logic                in_fire;
    logic                out_busy;
    logic [DIVD_W-1:0]   quot;
    logic                div_more;
    logic [31:0]         avg_sat;

    assign in_ready  = ctrl.op == OP_LOAD;
    assign in_fire   = in_valid && in_ready;
    assign out_busy  = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign interval  = now_reg - last_reg;
    assign avg_sat   = (|quot[DIVD_W-1:32]) ? 32'hFFFF_FFFF : quot[31:0];

    assign status.in_fire   = in_fire;
    assign status.uncapped  = period_reg == '0;
    assign status.short_win = span_reg < WINDOW_MS;
    assign status.div_more  = div_more;
    assign status.out_busy  = out_busy;

    fpws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.op == OP_DIVINIT),
        .step     (ctrl.op == OP_DIVSTEP),
        .dividend ({sum_reg, 8'd0}),
        .divisor  (fc_reg),
        .quotient (quot),
        .more     (div_more)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= '0;
            now_reg      <= '0;
            fc_reg       <= '0;
            last_reg     <= '0;
            ws_reg       <= '0;
            min_reg      <= MIN_RESTART;
            max_reg      <= '0;
            sum_reg      <= '0;
            prod_reg     <= '0;
            tgt_reg      <= '0;
            d_reg        <= '0;
            wait_reg     <= '0;
            eff_reg      <= '0;
            delta_reg    <= '0;
            span_reg     <= '0;
            done_reg     <= 1'b0;
            held_fps_reg <= '0;
            held_avg_reg <= '0;
            held_min_reg <= '0;
            held_max_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                period_reg <= cfg_wr_data;

            case (ctrl.op)
                OP_LOAD:
                begin
                    if (in_fire)
                    begin
                        now_reg  <= now_ms;
                        eff_reg  <= now_ms;
                        wait_reg <= '0;
                        done_reg <= 1'b0;
                        if (fc_reg != '1)
                            fc_reg <= fc_reg + 1'b1;
                    end
                end
                OP_INTV:
                begin
                    sum_reg  <= sat_add32(sum_reg, interval);
                    if (interval <= min_reg)
                        min_reg <= interval;
                    if (interval >= max_reg)
                        max_reg <= interval;
                    prod_reg <= {{PERIOD_W{1'b0}}, fc_reg} * {{COUNT_W{1'b0}}, period_reg};
                end
                OP_DEC:
                    prod_reg <= prod_reg - 1'b1;
                OP_TGT:
                    tgt_reg <= ws_reg + {2'b00, prod_reg[PROD_W-1:16]};
                OP_DIFF:
                    d_reg <= tgt_reg - now_reg;
                OP_WAIT:
                begin
                    // Target still ahead: hold the frame until it
                    if (d_reg != '0 && !d_reg[31])
                    begin
                        wait_reg <= d_reg;
                        eff_reg  <= tgt_reg;
                        sum_reg  <= sat_add32(sum_reg, d_reg);
                    end
                end
                OP_DELTA:
                begin
                    delta_reg <= eff_reg - last_reg;
                    last_reg  <= eff_reg;
                    span_reg  <= eff_reg - ws_reg;
                end
                OP_PUB:
                begin
                    held_fps_reg <= fc_reg;
                    held_avg_reg <= avg_sat;
                    held_min_reg <= min_reg;
                    held_max_reg <= max_reg;
                    done_reg     <= 1'b1;
                    fc_reg       <= '0;
                    min_reg      <= MIN_RESTART;
                    max_reg      <= '0;
                    sum_reg      <= '0;
                    ws_reg       <= eff_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            wait_ms       <= '0;
            delta_ms      <= '0;
            window_done   <= 1'b0;
            fps           <= '0;
            avg_ms_q8     <= '0;
            min_ms        <= '0;
            max_ms        <= '0;
        end
        else
        begin
            if (ctrl.op == OP_OUT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
                wait_ms       <= wait_reg;
                delta_ms      <= delta_reg;
                window_done   <= done_reg;
                fps           <= held_fps_reg;
                avg_ms_q8     <= held_avg_reg;
                min_ms        <= held_min_reg;
                max_ms        <= held_max_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/frame_pacer_with_window_stats.sv
// Each input beat is processed to a result; the capped path adds the target and wait steps,
// and a frame that closes the window also runs the 40-step average divider.
// One frame at a time: the next input beat can be taken in the cycle after the
// result is registered.
// Reset (rst_n, asynchronous, active low) clears the window, the held
// statistics and the frame period, and sets the window minimum to 1000.
module frame_pacer_with_window_stats
    import fpws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [PERIOD_W-1:0]  cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [31:0]          now_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          wait_ms,
    output logic [31:0]          delta_ms,
    output logic                 window_done,
    output logic [COUNT_W-1:0]   fps,
    output logic [31:0]          avg_ms_q8,
    output logic [31:0]          min_ms,
    output logic [31:0]          max_ms
);

    ctrl_t   ctrl;
    status_t status;

    fpws_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    fpws_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .wait_ms     (wait_ms),
        .delta_ms    (delta_ms),
        .window_done (window_done),
        .fps         (fps),
        .avg_ms_q8   (avg_ms_q8),
        .min_ms      (min_ms),
        .max_ms      (max_ms)
    );

endmodule

FILE: rtl/fpws_chk.sv
module fpws_chk
    import fpws_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [31:0]          now_ms,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [31:0]          wait_ms,
    input logic [31:0]          delta_ms,
    input logic                 window_done,
    input logic [COUNT_W-1:0]   fps,
    input logic [31:0]          avg_ms_q8,
    input logic [31:0]          min_ms,
    input logic [31:0]          max_ms
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // One frame in flight: an input beat closes the input side next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a frame is in flight");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({wait_ms, delta_ms, window_done, fps, avg_ms_q8, min_ms, max_ms}))
        else $error("result payload changed while stalled");

    // A waiting input beat stays offered with its time unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(now_ms))
        else $error("input beat withdrawn or changed while waiting");

    // A closed window has counted frames and a consistent range
    a_window_stats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_done |-> fps != '0 && min_ms <= max_ms)
        else $error("published window statistics inconsistent");

endmodule

bind frame_pacer_with_window_stats fpws_chk u_chk (.*);
